/* hdl/swpf_pkg.sv */
// Shared types, constants and helpers for the servo write packet framer.
package swpf_pkg;

    localparam logic [7:0] SYNC_BYTE    = 8'hFF;
    localparam logic [7:0] PKT_LEN      = 8'd5;
    localparam int         PKT_BYTES    = 9;
    localparam int         IDX_W        = $clog2(PKT_BYTES);
    localparam logic [15:0] MAX_DEGREES = 16'd300;
    localparam logic [15:0] MAX_RAW     = 16'd1023;

    // floor(deg * 1023 / 300) == (deg * SCALE_MUL) >> SCALE_SHIFT for deg <= 300
    localparam logic [17:0] SCALE_MUL   = 18'd223478;
    localparam int          SCALE_SHIFT = 16;

    // Operation codes
    localparam logic OP_ANGLE = 1'b0;
    localparam logic OP_SPEED = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ANGLE = 2'd1;
    localparam logic [1:0] ST_BAD_ID    = 2'd2;
    localparam logic [1:0] ST_BAD_SPEED = 2'd3;

    // Configuration register indexes
    localparam logic [7:0] CFG_MAX_ID    = 8'd0;
    localparam logic [7:0] CFG_WR_INSTR  = 8'd1;
    localparam logic [7:0] CFG_POS_REG   = 8'd2;
    localparam logic [7:0] CFG_SPEED_REG = 8'd3;

    typedef struct packed {
        logic [7:0] max_servo_id;
        logic [7:0] write_instruction;
        logic [7:0] goal_position_reg;
        logic [7:0] goal_speed_reg;
    } t_cfg;

    // Checked and scaled request, ready for framing
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] id;
        logic [7:0] instr;
        logic [7:0] addr;
        logic [9:0] value;
    } t_req;

    function automatic logic [7:0] pkt_checksum(input t_req req);
        logic [10:0] sum;
        sum = {3'b0, req.id} + {3'b0, PKT_LEN} + {3'b0, req.instr} + {3'b0, req.addr}
            + {3'b0, req.value[7:0]} + {9'b0, req.value[9:8]};
        return ~sum[7:0];
    endfunction

endpackage

/* hdl/swpf_encode.sv */
// Request check and goal angle scaling for the servo write packet framer.
module swpf_encode (
    input  logic             i_operation,
    input  logic [7:0]       i_servo_id,
    input  logic [15:0]      i_command_value,
    input  swpf_pkg::t_cfg   i_cfg,
    output swpf_pkg::t_req   o_req
);
    import swpf_pkg::*;

    logic [26:0] scaled_prod;
    logic [9:0]  scaled;

    // degrees above 300 never reach a packet, so 9 bits cover the product input
    assign scaled_prod = {18'b0, i_command_value[8:0]} * {9'b0, SCALE_MUL};
    assign scaled      = scaled_prod[SCALE_SHIFT +: 10];

    always_comb begin
        o_req.id    = i_servo_id;
        o_req.instr = i_cfg.write_instruction;
        if (i_operation == OP_ANGLE) begin
            o_req.addr  = i_cfg.goal_position_reg;
            o_req.value = scaled;
            if (i_command_value > MAX_DEGREES) begin
                o_req.status = ST_BAD_ANGLE;
            end else if (i_servo_id == 8'd0 || i_servo_id > i_cfg.max_servo_id) begin
                o_req.status = ST_BAD_ID;
            end else begin
                o_req.status = ST_OK;
            end
        end else begin
            o_req.addr   = i_cfg.goal_speed_reg;
            o_req.value  = i_command_value[9:0];
            o_req.status = (i_command_value > MAX_RAW) ? ST_BAD_SPEED : ST_OK;
        end
    end

endmodule

/* hdl/servo_write_packet_framer.sv */
// Servo write packet framer: request check, scaling and nine-byte serializer.
// The first beat of a packet (or the error beat) is presented once the accepted
//   request beat has passed the stage 1 and stage 2 registers.
// Throughput: one request per nine output beats for a packet, one per beat for
//   an error; the byte serializer sets that figure.
// Reset (synchronous, active low) empties both stages and loads the config
//   registers with max id 1, instruction 3, position reg 30, speed reg 32.
module servo_write_packet_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_servo_id,
    input  logic [15:0] i_command_value,
    // byte channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_byte,
    output logic [1:0]  o_status,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import swpf_pkg::*;

    // Config registers
    t_cfg r_cfg;

    // Stage 1: checked request
    logic r_req_valid;
    t_req r_req;
    t_req n_req;

    // Stage 2: packet being serialized
    logic             r_pkt_valid;
    logic [IDX_W-1:0] r_idx;
    t_req             r_pkt;
    logic [7:0]       r_chk;

    logic in_fire, out_fire, pkt_done, load_pkt, req_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_servo_id      <= 8'd1;
            r_cfg.write_instruction <= 8'd3;
            r_cfg.goal_position_reg <= 8'd30;
            r_cfg.goal_speed_reg    <= 8'd32;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MAX_ID:    r_cfg.max_servo_id      <= i_cfg_data;
                CFG_WR_INSTR:  r_cfg.write_instruction <= i_cfg_data;
                CFG_POS_REG:   r_cfg.goal_position_reg <= i_cfg_data;
                CFG_SPEED_REG: r_cfg.goal_speed_reg    <= i_cfg_data;
                default: ; // unknown index: ignored
            endcase
        end
    end

    swpf_encode u_encode (
        .i_operation     (i_operation),
        .i_servo_id      (i_servo_id),
        .i_command_value (i_command_value),
        .i_cfg           (r_cfg),
        .o_req           (n_req)
    );

    // Handshake: stage 2 frees up on the beat that closes its packet, so the next
    // packet follows with no gap; stage 1 acts as the skid between the sides.
    assign out_fire   = r_pkt_valid && !i_out_stall;
    assign pkt_done   = out_fire && o_last_byte;
    assign load_pkt   = r_req_valid && (!r_pkt_valid || pkt_done);
    assign req_free   = !r_req_valid || load_pkt;
    assign o_in_stall = !req_free;
    assign in_fire    = i_in_valid && req_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (in_fire) begin
            r_req_valid <= 1'b1;
        end else if (load_pkt) begin
            r_req_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req <= n_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_valid <= 1'b0;
            r_idx       <= '0;
        end else if (load_pkt) begin
            r_pkt_valid <= 1'b1;
            r_idx       <= '0;
        end else if (pkt_done) begin
            r_pkt_valid <= 1'b0;
        end else if (out_fire) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_pkt) begin
            r_pkt <= r_req;
            r_chk <= pkt_checksum(r_req);
        end
    end

    // Byte select over the registered packet fields
    always_comb begin
        case (r_idx)
            IDX_W'(0): o_tx_byte = SYNC_BYTE;
            IDX_W'(1): o_tx_byte = SYNC_BYTE;
            IDX_W'(2): o_tx_byte = r_pkt.id;
            IDX_W'(3): o_tx_byte = PKT_LEN;
            IDX_W'(4): o_tx_byte = r_pkt.instr;
            IDX_W'(5): o_tx_byte = r_pkt.addr;
            IDX_W'(6): o_tx_byte = r_pkt.value[7:0];
            IDX_W'(7): o_tx_byte = {6'b0, r_pkt.value[9:8]};
            default:   o_tx_byte = r_chk;
        endcase
        // an error result is a single zero beat
        if (r_pkt.status != ST_OK) begin
            o_tx_byte = 8'd0;
        end
    end

    assign o_out_valid = r_pkt_valid;
    assign o_status    = r_pkt.status;
    assign o_last_byte = (r_pkt.status != ST_OK) || (r_idx == IDX_W'(PKT_BYTES - 1));

endmodule

/* hdl/swpf_checker.sv */
// Port-level checks for the servo write packet framer, bound to the top level.
module swpf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_tx_byte,
    input logic       o_last_byte,
    input logic [1:0] o_status
);
    import swpf_pkg::*;

    // an error result is one zero beat that closes itself
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_last_byte && o_tx_byte == 8'd0)
        else $error("error beat not single zero beat");

    // a stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_tx_byte) && $stable(o_last_byte) && $stable(o_status))
        else $error("stalled beat changed");

    // packet bytes follow without gaps and keep ok status until the last one
    a_pkt_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_byte |=> o_out_valid && o_status == ST_OK)
        else $error("packet broken before last byte");

    // a packet that directly follows a closed one opens with a sync byte
    a_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_last_byte ##1 o_out_valid && o_status == ST_OK
            |-> o_tx_byte == SYNC_BYTE)
        else $error("packet does not open with sync byte");

endmodule

bind servo_write_packet_framer swpf_checker u_swpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_tx_byte   (o_tx_byte),
    .o_last_byte (o_last_byte),
    .o_status    (o_status)
);
